// ===== sv/deq_pkg.sv =====
// Shared constants, types and helper functions for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int OCC_W       = $clog2(DEPTH + 1);
   localparam int CMD_W       = 3;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_LIST       = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADDR = 3'b010,
      ST_DATA = 3'b100
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] base;
      logic [OCC_W-1:0] offset;
   } ptr_req_type;

   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] data;
      status_type        status;
      logic              last;
   } rsp_load_type;

   function automatic logic [DATA_WIDTH-1:0] store_word(input logic [WORD_W-1:0] din);
      logic [63:0] wide;
      wide = 64'(din);
      return wide[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] out_word(input logic [DATA_WIDTH-1:0] w);
      logic [63:0] wide;
      wide = 64'(w);
      return wide[WORD_W-1:0];
   endfunction

endpackage

// ===== sv/deq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/deq_ptr.sv =====
// Shared ring index unit: adds an offset to a base position modulo the queue depth.
`timescale 1ns / 1ps

module deq_ptr (
   input  deq_pkg::ptr_req_type       req,
   output logic [deq_pkg::IDX_W-1:0]  pos
);

   localparam int SUM_W = deq_pkg::OCC_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   always_comb begin
      sum = SUM_W'(req.base) + SUM_W'(req.offset);
      if (sum >= SUM_W'(deq_pkg::DEPTH)) begin
         wrapped = sum - SUM_W'(deq_pkg::DEPTH);
      end else begin
         wrapped = sum;
      end
   end

   assign pos = wrapped[deq_pkg::IDX_W-1:0];

endmodule

// ===== sv/deq_seq.sv =====
// Command sequencer: holds the head and fill count and steps each command through the index unit.
`timescale 1ns / 1ps

module deq_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [deq_pkg::CMD_W-1:0]        req_cmd,
   input  logic [deq_pkg::WORD_W-1:0]       req_data,
   output logic                             req_ready,
   input  logic                             out_free,
   output deq_pkg::ptr_req_type             ptr_req,
   input  logic [deq_pkg::IDX_W-1:0]        ptr_pos,
   output logic                             ram_wr_en,
   output logic [deq_pkg::IDX_W-1:0]        ram_wr_addr,
   output logic [deq_pkg::DATA_WIDTH-1:0]   ram_wr_data,
   output logic                             ram_rd_en,
   output logic [deq_pkg::IDX_W-1:0]        ram_rd_addr,
   input  logic [deq_pkg::DATA_WIDTH-1:0]   ram_rd_data,
   output deq_pkg::rsp_load_type            rsp_load
);

   localparam int IDX_W = deq_pkg::IDX_W;
   localparam int OCC_W = deq_pkg::OCC_W;

   deq_pkg::state_type               state_ff, state_in;
   logic [deq_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [deq_pkg::DATA_WIDTH-1:0]   data_ff, data_in;
   logic [IDX_W-1:0]                 head_ff, head_in;
   logic [OCC_W-1:0]                 occ_ff, occ_in;
   logic [IDX_W-1:0]                 cnt_ff, cnt_in;
   logic                             is_full;
   logic                             is_empty;
   logic                             list_last;

   assign is_full   = (occ_ff == OCC_W'(deq_pkg::DEPTH));
   assign is_empty  = (occ_ff == '0);
   assign list_last = ((OCC_W'(cnt_ff) + OCC_W'(1)) == occ_ff);
   assign req_ready = (state_ff == deq_pkg::ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      data_in         = data_ff;
      head_in         = head_ff;
      occ_in          = occ_ff;
      cnt_in          = cnt_ff;
      ptr_req.base    = head_ff;
      ptr_req.offset  = '0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = ptr_pos;
      ram_wr_data     = data_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = ptr_pos;
      rsp_load.load   = 1'b0;
      rsp_load.data   = '0;
      rsp_load.status = deq_pkg::STATUS_OK;
      rsp_load.last   = 1'b1;

      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               data_in = deq_pkg::store_word(req_data);
               cnt_in  = '0;
               if (req_cmd <= deq_pkg::CMD_LIST) begin
                  state_in = deq_pkg::ST_ADDR;
               end
            end
         end
         deq_pkg::ST_ADDR: begin
            unique case (deq_pkg::cmd_type'(cmd_ff))
               deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                  if (cmd_ff == deq_pkg::CMD_PUSH_FRONT) begin
                     ptr_req.offset = OCC_W'(deq_pkg::DEPTH - 1);
                  end else begin
                     ptr_req.offset = occ_ff;
                  end
                  if (out_free) begin
                     rsp_load.load = 1'b1;
                     state_in      = deq_pkg::ST_IDLE;
                     if (is_full) begin
                        rsp_load.status = deq_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        occ_in    = occ_ff + OCC_W'(1);
                        if (cmd_ff == deq_pkg::CMD_PUSH_FRONT) begin
                           head_in = ptr_pos;
                        end
                     end
                  end
               end
               deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
                  if (cmd_ff == deq_pkg::CMD_POP_FRONT) begin
                     ptr_req.offset = OCC_W'(1);
                  end else begin
                     ptr_req.offset = occ_ff - OCC_W'(1);
                  end
                  if (is_empty) begin
                     if (out_free) begin
                        rsp_load.load   = 1'b1;
                        rsp_load.status = deq_pkg::STATUS_EMPTY;
                        state_in        = deq_pkg::ST_IDLE;
                     end
                  end else begin
                     ram_rd_en = 1'b1;
                     occ_in    = occ_ff - OCC_W'(1);
                     state_in  = deq_pkg::ST_DATA;
                     if (cmd_ff == deq_pkg::CMD_POP_FRONT) begin
                        ram_rd_addr = head_ff;
                        head_in     = ptr_pos;
                     end
                  end
               end
               deq_pkg::CMD_LIST: begin
                  ptr_req.offset = OCC_W'(cnt_ff);
                  if (is_empty) begin
                     if (out_free) begin
                        rsp_load.load   = 1'b1;
                        rsp_load.status = deq_pkg::STATUS_EMPTY;
                        state_in        = deq_pkg::ST_IDLE;
                     end
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = deq_pkg::ST_DATA;
                  end
               end
               default: begin
                  state_in = deq_pkg::ST_IDLE;
               end
            endcase
         end
         deq_pkg::ST_DATA: begin
            if (out_free) begin
               rsp_load.load = 1'b1;
               rsp_load.data = deq_pkg::out_word(ram_rd_data);
               if (cmd_ff == deq_pkg::CMD_LIST) begin
                  rsp_load.last = list_last;
                  if (list_last) begin
                     state_in = deq_pkg::ST_IDLE;
                  end else begin
                     cnt_in   = cnt_ff + IDX_W'(1);
                     state_in = deq_pkg::ST_ADDR;
                  end
               end else begin
                  state_in = deq_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: sequencer, index unit, entry RAM and result register.
//
//   Channel  Direction  Beat contents
//   req      in         tdata: command [2:0], data_in [34:3]
//   rsp      out        tdata: data_out [31:0], status [33:32]; tlast: last
//
// An insert writes its entry and loads its result in the address state. A removal reads in the
// address state and returns the word from the data state, or ends there when the queue is empty;
// a list repeats both states per stored word. Back removals and list reads address the registered
// RAM read port through the shared index adder, front removals at the head. Reset clears the head
// position and fill count, not the entries. A stalled result holds its loading state until freed.
`timescale 1ns / 1ps

module double_ended_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: command (3), data_in (32), zero fill.
   input  logic [deq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: data_out (32), status (2), zero fill.
   output logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int PAD_W = deq_pkg::RSP_TDATA_W - deq_pkg::WORD_W - deq_pkg::STATUS_W;

   deq_pkg::ptr_req_type                ptr_req;
   deq_pkg::rsp_load_type               rsp_load;
   logic [deq_pkg::IDX_W-1:0]           ptr_pos;
   logic                                ram_wr_en;
   logic [deq_pkg::IDX_W-1:0]           ram_wr_addr;
   logic [deq_pkg::DATA_WIDTH-1:0]      ram_wr_data;
   logic                                ram_rd_en;
   logic [deq_pkg::IDX_W-1:0]           ram_rd_addr;
   logic [deq_pkg::DATA_WIDTH-1:0]      ram_rd_data;
   logic                                out_free;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::WORD_W-1:0]          rsp_data_ff, rsp_data_in;
   deq_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   deq_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_cmd     (req_tdata[deq_pkg::CMD_W-1:0]),
      .req_data    (req_tdata[deq_pkg::CMD_W +: deq_pkg::WORD_W]),
      .req_ready   (req_tready),
      .out_free    (out_free),
      .ptr_req     (ptr_req),
      .ptr_pos     (ptr_pos),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_load    (rsp_load)
   );

   deq_ptr u_ptr (
      .req (ptr_req),
      .pos (ptr_pos)
   );

   deq_ram #(
      .WIDTH (deq_pkg::DATA_WIDTH),
      .DEPTH (deq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_load.load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = rsp_load.data;
         rsp_status_in = rsp_load.status;
         rsp_last_in   = rsp_load.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_status_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
